// ----- rtl/imh_pkg.sv -----
`default_nettype none
package imh_pkg;

  localparam int CAPACITY = 256;
  localparam int KEY_BITS = 31;
  localparam int ID_BITS  = 8;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int SLOT_W   = ADDR_W + 1;

  localparam logic [1:0] MODE_INSERT   = 2'd0;
  localparam logic [1:0] MODE_DELETE   = 2'd1;
  localparam logic [1:0] MODE_DECREASE = 2'd2;
  localparam logic [1:0] MODE_NONE     = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_IGNORED   = 3'd3;
  localparam logic [2:0] ST_DUPLICATE = 3'd4;

  typedef struct packed {
    logic [1:0]          mode;
    logic [ID_BITS-1:0]  item_id;
    logic [KEY_BITS-1:0] key;
  } imh_in_t;

  typedef struct packed {
    logic [ID_BITS-1:0]  out_id;
    logic [KEY_BITS-1:0] out_key;
    logic [2:0]          status;
    logic                is_empty;
  } imh_out_t;

  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic [KEY_BITS-1:0] key;
  } imh_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DEC_POS,
    S_DEC_CHK,
    S_DEL_WAIT,
    S_DN_RD,
    S_DN_CMP
  } imh_state_t;

endpackage
`default_nettype wire

// ----- rtl/indexed_min_heap_core.sv -----
`default_nettype none
// Indexed binary min-heap of (id, key) entries with an id-to-slot map.
// Input channel: in_data is taken at a clock edge where start is high and
// busy is low. mode selects insert, delete-minimum, decrease-key or no operation.
// Result channel: one result beat per command, shown on out_data for one
// cycle with out_valid high; the receiver cannot stall it.
// Steps: a command rejected at acceptance has its result beat registered
// at the accept edge; a decrease-key first reads the id-to-slot map and
// the slot's entry, and one refused on its key ends there. Insert and
// decrease-key walk up a level at a time (up to 8 levels), reading the
// parent and moving it down while it is larger, then place the entry.
// Delete-minimum reads the root and last entries, walks down (up to 7
// levels) moving the smaller child up, then places the entry.
// Throughput: one command at a time; busy drops as the result beat starts.
// The heap memory is read through two ports with registered read data.
// Reset: entry count cleared and every id marked absent at once through
// per-id valid flops; heap slot contents are not cleared.
module indexed_min_heap_core (
  input  wire                logic     clk,
  input  wire                logic     rst_n,
  input  wire                logic     start,
  output                     logic     busy,
  input  wire imh_pkg::imh_in_t        in_data,
  output                     logic     out_valid,
  output imh_pkg::imh_out_t            out_data
);
  import imh_pkg::*;

  imh_entry_t heap_mem [CAPACITY];
  logic [SLOT_W-1:0] pos_mem [2**ID_BITS];

  imh_state_t state_r, state_nxt;
  logic [SLOT_W-1:0] k_r, k_nxt;
  logic [SLOT_W-1:0] count_r, count_nxt;
  imh_entry_t cur_r, cur_nxt;
  imh_entry_t m_r, m_nxt;
  imh_in_t req_r, req_nxt;
  logic [2**ID_BITS-1:0] valid_r;
  logic out_valid_r, out_valid_nxt;
  imh_out_t out_r, out_nxt;

  logic [ADDR_W-1:0] rd_a_addr, rd_b_addr, wr_addr;
  imh_entry_t rd_a_q, rd_b_q, wr_data;
  logic wr_en;
  logic [SLOT_W-1:0] pos_q, pos_wr_data;
  logic [ID_BITS-1:0] pos_wr_addr;
  logic pos_wr_en;
  logic clr_en;
  logic [ID_BITS-1:0] clr_id;

  logic [SLOT_W:0] child;
  logic [SLOT_W-1:0] sel_slot, par_slot;
  imh_entry_t sel;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    rd_a_q <= heap_mem[rd_a_addr];
    rd_b_q <= heap_mem[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (pos_wr_en) begin
      pos_mem[pos_wr_addr] <= pos_wr_data;
    end
    pos_q <= pos_mem[in_data.item_id];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (pos_wr_en) begin
        valid_r[pos_wr_addr] <= 1'b1;
      end
      if (clr_en) begin
        valid_r[clr_id] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    cur_r <= cur_nxt;
    m_r   <= m_nxt;
    req_r <= req_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    child    = {k_r, 1'b0};
    par_slot = k_r >> 1;
    if ((child < {1'b0, count_r}) && (rd_a_q.key > rd_b_q.key)) begin
      sel      = rd_b_q;
      sel_slot = child[SLOT_W-1:0] + SLOT_W'(1);
    end else begin
      sel      = rd_a_q;
      sel_slot = child[SLOT_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    m_nxt         = m_r;
    req_nxt       = req_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_a_addr     = '0;
    rd_b_addr     = '0;
    wr_en         = 1'b0;
    wr_addr       = ADDR_W'(k_r - SLOT_W'(1));
    wr_data       = cur_r;
    pos_wr_en     = 1'b0;
    pos_wr_addr   = cur_r.id;
    pos_wr_data   = k_r;
    clr_en        = 1'b0;
    clr_id        = m_r.id;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt     = in_data;
          cur_nxt.id  = in_data.item_id;
          cur_nxt.key = in_data.key;
          m_nxt       = '0;
          out_nxt     = '0;
          case (in_data.mode)
            MODE_INSERT: begin
              if (valid_r[in_data.item_id]) begin
                out_nxt.status = ST_DUPLICATE;
                out_valid_nxt  = 1'b1;
              end else if (count_r == SLOT_W'(CAPACITY)) begin
                out_nxt.status = ST_FULL;
                out_valid_nxt  = 1'b1;
              end else begin
                count_nxt = count_r + SLOT_W'(1);
                k_nxt     = count_r + SLOT_W'(1);
                state_nxt = S_UP_RD;
              end
            end
            MODE_DELETE: begin
              if (count_r == '0) begin
                out_nxt.status = ST_EMPTY;
                out_valid_nxt  = 1'b1;
              end else begin
                rd_a_addr = '0;
                rd_b_addr = ADDR_W'(count_r - SLOT_W'(1));
                state_nxt = S_DEL_WAIT;
              end
            end
            MODE_DECREASE: begin
              if (!valid_r[in_data.item_id]) begin
                out_nxt.status = ST_IGNORED;
                out_valid_nxt  = 1'b1;
              end else begin
                state_nxt = S_DEC_POS;
              end
            end
            default: begin
              out_nxt.status = ST_OK;
              out_valid_nxt  = 1'b1;
            end
          endcase
          out_nxt.is_empty = (count_nxt == '0);
        end
      end
      S_UP_RD: begin
        if (k_r == SLOT_W'(1)) begin
          wr_en     = 1'b1;
          pos_wr_en = 1'b1;
          out_nxt.is_empty = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          rd_a_addr = ADDR_W'(par_slot - SLOT_W'(1));
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        pos_wr_en = 1'b1;
        if (rd_a_q.key > cur_r.key) begin
          wr_data     = rd_a_q;
          pos_wr_addr = rd_a_q.id;
          k_nxt       = par_slot;
          state_nxt   = S_UP_RD;
        end else begin
          out_nxt.is_empty = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DEC_POS: begin
        k_nxt     = pos_q;
        rd_a_addr = ADDR_W'(pos_q - SLOT_W'(1));
        state_nxt = S_DEC_CHK;
      end
      S_DEC_CHK: begin
        if ((k_r != '0) && (k_r <= count_r) && (req_r.key < rd_a_q.key)) begin
          state_nxt = S_UP_RD;
        end else begin
          out_nxt.status = ST_IGNORED;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_DEL_WAIT: begin
        m_nxt     = rd_a_q;
        cur_nxt   = rd_b_q;
        clr_en    = 1'b1;
        clr_id    = rd_a_q.id;
        count_nxt = count_r - SLOT_W'(1);
        k_nxt     = SLOT_W'(1);
        if (count_nxt == '0) begin
          out_nxt.out_id   = rd_a_q.id;
          out_nxt.out_key  = rd_a_q.key;
          out_nxt.is_empty = 1'b1;
          out_valid_nxt    = 1'b1;
          state_nxt        = S_IDLE;
        end else begin
          state_nxt = S_DN_RD;
        end
      end
      S_DN_RD: begin
        if (child > {1'b0, count_r}) begin
          wr_en     = 1'b1;
          pos_wr_en = 1'b1;
          out_nxt.out_id   = m_r.id;
          out_nxt.out_key  = m_r.key;
          out_nxt.is_empty = 1'b0;
          out_valid_nxt    = 1'b1;
          state_nxt        = S_IDLE;
        end else begin
          rd_a_addr = ADDR_W'(child - (SLOT_W+1)'(1));
          rd_b_addr = ADDR_W'(child);
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        wr_en     = 1'b1;
        pos_wr_en = 1'b1;
        if (cur_r.key > sel.key) begin
          wr_data     = sel;
          pos_wr_addr = sel.id;
          k_nxt       = sel_slot;
          state_nxt   = S_DN_RD;
        end else begin
          out_nxt.out_id   = m_r.id;
          out_nxt.out_key  = m_r.key;
          out_nxt.is_empty = 1'b0;
          out_valid_nxt    = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
